@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable.
`define CFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Implication form: when the antecedent holds, the consequent holds in the next cycle.
`define CFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `CFA_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ hw/rtl/cfa_pkg.sv @@
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and constants of the contiguous fit allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_WIDTH   = 24;
    localparam int OWNER_WIDTH  = 8;
    localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = SEG_AW + 1;
    localparam logic [ADDR_WIDTH-1:0] MEM_SIZE_RESET = ADDR_WIDTH'(10000000);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_COMPACT = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_BAD   = 2'd3
    } fit_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_MODE = 3'd1,
        ST_NO_HOLE  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NO_OWNER = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]             op;
        logic [OWNER_WIDTH-1:0] owner_id;
        logic [ADDR_WIDTH-1:0]  request_size;
        logic [1:0]             fit_mode;
    } req_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [ADDR_WIDTH-1:0] base_address;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0]  base;
        logic [ADDR_WIDTH-1:0]  size;
        logic [OWNER_WIDTH-1:0] owner;
    } seg_t;

endpackage

@@ hw/rtl/cfa_if.sv @@
// ----------------------------------------------------------------------------
// cfa_if
// Valid/ready channels of the allocator: requests, responses, configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfa_req_if;
    logic          valid;
    logic          ready;
    cfa_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfa_rsp_if;
    logic          valid;
    logic          ready;
    cfa_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cfa_pkg::ADDR_WIDTH-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/cfa_ram.sv @@
// ----------------------------------------------------------------------------
// cfa_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/contiguous_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Segment table allocator with first, best and worst fit, release and compact.
// ----------------------------------------------------------------------------
// The segment table sits in one RAM with a registered read, and every operation
// that passes its checks walks it one entry at a time, reading an entry and then
// evaluating or writing it. Checks that fail at once (bad mode, full table, zero
// size, unknown op) answer without a walk. One request is handled at a time; the
// response register holds the last result until it is taken. Configuration beats
// are accepted at any time.
`timescale 1ns / 1ps

module contiguous_fit_allocator (
    input  logic       clk,
    input  logic       rst_n,
    cfa_req_if.sink    req,
    cfa_rsp_if.source  rsp,
    cfa_cfg_if.sink    cfg
);

    import cfa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_EV    = 7'b0000100,
        S_SHRD  = 7'b0001000,
        S_SHWR  = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_WIDTH-1:0]  mem_size_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]       pick_reg, pick_next;
    logic                   found_reg, found_next;
    logic [ADDR_WIDTH:0]    pick_len_reg, pick_len_next;
    logic [ADDR_WIDTH-1:0]  pick_start_reg, pick_start_next;
    logic [ADDR_WIDTH:0]    prev_end_reg, prev_end_next;
    logic [ADDR_WIDTH-1:0]  cpt_next_reg, cpt_next_next;
    req_t                   cmd_reg, cmd_next;
    rsp_t                   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_reg, out_next;

    logic                   ram_we;
    logic [SEG_AW-1:0]      ram_waddr, ram_raddr;
    seg_t                   ram_wdata, ram_rdata;

    logic [ADDR_WIDTH:0]    hole_end, hole_len;
    logic                   fits, better;

    cfa_ram #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Hole in front of entry idx; past the last entry it runs to the memory end.
    always_comb
    begin
        hole_end = (idx_reg < count_reg) ? {1'b0, ram_rdata.base} : {1'b0, mem_size_reg};
        hole_len = (hole_end > prev_end_reg) ? (hole_end - prev_end_reg) : '0;
        fits     = (hole_len >= {1'b0, cmd_reg.request_size});
        better   = !found_reg
                 || ((cmd_reg.fit_mode == FIT_BEST)  && (hole_len < pick_len_reg))
                 || ((cmd_reg.fit_mode == FIT_WORST) && (hole_len > pick_len_reg));
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        pick_len_next   = pick_len_reg;
        pick_start_next = pick_start_reg;
        prev_end_next   = prev_end_reg;
        cpt_next_next   = cpt_next_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[SEG_AW-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[SEG_AW-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = req.data;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    prev_end_next = '0;
                    cpt_next_next = '0;
                    res_next      = '{status: ST_OK, base_address: '0};
                    state_next    = S_RD;
                    priority case (req.data.op)
                        OP_ALLOC:
                        begin
                            if (req.data.fit_mode == FIT_BAD)
                            begin
                                res_next.status = ST_BAD_MODE;
                                state_next      = S_DONE;
                            end
                            else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (req.data.request_size == '0)
                            begin
                                res_next.status = ST_NO_HOLE;
                                state_next      = S_DONE;
                            end
                        end
                        OP_RELEASE, OP_COMPACT:
                        begin
                        end
                        default:
                        begin
                            res_next.status = ST_BAD_MODE;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if ((cmd_reg.op != OP_ALLOC) && (idx_reg >= count_reg))
                begin
                    if (cmd_reg.op == OP_RELEASE)
                    begin
                        res_next.status = ST_NO_OWNER;
                    end
                    else
                    begin
                        res_next.base_address = cpt_next_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_EV;
                end
            end

            S_EV:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_RD;
                priority case (cmd_reg.op)
                    OP_ALLOC:
                    begin
                        prev_end_next = {1'b0, ram_rdata.base} + {1'b0, ram_rdata.size};
                        if (fits && better)
                        begin
                            found_next      = 1'b1;
                            pick_next       = idx_reg;
                            pick_len_next   = hole_len;
                            pick_start_next = prev_end_reg[ADDR_WIDTH-1:0];
                        end
                        if ((idx_reg == count_reg)
                            || (fits && (cmd_reg.fit_mode == FIT_FIRST)))
                        begin
                            if (found_next)
                            begin
                                k_next     = count_reg;
                                state_next = S_SHRD;
                            end
                            else
                            begin
                                res_next.status = ST_NO_HOLE;
                                state_next      = S_DONE;
                            end
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (ram_rdata.owner == cmd_reg.owner_id)
                        begin
                            k_next     = idx_reg;
                            state_next = S_SHRD;
                        end
                    end
                    default:
                    begin
                        // Compact: the entry moves down to the running end address.
                        ram_we         = 1'b1;
                        ram_wdata.base = cpt_next_reg;
                        cpt_next_next  = cpt_next_reg + ram_rdata.size;
                    end
                endcase
            end

            S_SHRD:
            begin
                if (cmd_reg.op == OP_ALLOC)
                begin
                    ram_raddr  = SEG_AW'(k_reg - 1'b1);
                    state_next = (k_reg > pick_reg) ? S_SHWR : S_PUT;
                end
                else
                begin
                    ram_raddr = SEG_AW'(k_reg + 1'b1);
                    if ((k_reg + 1'b1) < count_reg)
                    begin
                        state_next = S_SHWR;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_SHWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[SEG_AW-1:0];
                k_next     = (cmd_reg.op == OP_ALLOC) ? (k_reg - 1'b1) : (k_reg + 1'b1);
                state_next = S_SHRD;
            end

            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pick_reg[SEG_AW-1:0];
                ram_wdata = '{base: pick_start_reg, size: cmd_reg.request_size,
                              owner: cmd_reg.owner_id};
                count_next            = count_reg + 1'b1;
                res_next.base_address = pick_start_reg;
                state_next            = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            mem_size_reg  <= MEM_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                mem_size_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        pick_reg       <= pick_next;
        found_reg      <= found_next;
        pick_len_reg   <= pick_len_next;
        pick_start_reg <= pick_start_next;
        prev_end_reg   <= prev_end_next;
        cpt_next_reg   <= cpt_next_next;
        cmd_reg        <= cmd_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule

@@ hw/rtl/cfa_checker.sv @@
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level assertions on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status,
    input logic [cfa_pkg::ADDR_WIDTH-1:0] rsp_base
);

    import cfa_pkg::*;

    // A response beat waits until it is taken.
    `CFA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // One request at a time: after a beat is taken the block is busy.
    `CFA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // Status codes stay within the defined set.
    `CFA_ASSERT(a_status_range, clk, rst_n, rsp_valid |-> (rsp_status <= ST_NO_OWNER))

    // A failed operation reports base zero.
    `CFA_ASSERT(a_fail_base, clk, rst_n, (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_base == '0))

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.data.status),
    .rsp_base   (rsp.data.base_address)
);

@@ tb/tb_contiguous_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_contiguous_fit_allocator
// Drives allocate, release, compact and unknown-op beats with random idling on both
// channels, predicts each response from a shadow segment table and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_contiguous_fit_allocator;
    import cfa_pkg::*;

    logic clk;
    logic rst_n;

    cfa_req_if req_ch ();
    cfa_rsp_if rsp_ch ();
    cfa_cfg_if cfg_ch ();

    contiguous_fit_allocator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // Shadow allocator state.
    logic [ADDR_WIDTH-1:0]  shadow_mem_size;
    logic [ADDR_WIDTH-1:0]  shadow_base [MAX_SEGMENTS];
    logic [ADDR_WIDTH-1:0]  shadow_size [MAX_SEGMENTS];
    logic [OWNER_WIDTH-1:0] shadow_owner [MAX_SEGMENTS];
    int                     shadow_count;

    req_t   pending_reqs [$];
    rsp_t   expected_rsps [$];
    int     error_count;
    int     cycle_count;
    bit     quiet_phase;
    logic [ADDR_WIDTH-1:0] cfg_pending;
    bit     cfg_go;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [ADDR_WIDTH:0] hole_from(int i);
        if (i == 0)
            return '0;
        return {1'b0, shadow_base[i-1]} + {1'b0, shadow_size[i-1]};
    endfunction

    function automatic logic [ADDR_WIDTH:0] hole_length(int i);
        logic [ADDR_WIDTH:0] s;
        logic [ADDR_WIDTH:0] e;
        s = hole_from(i);
        e = (i < shadow_count) ? {1'b0, shadow_base[i]} : {1'b0, shadow_mem_size};
        return (e > s) ? e - s : '0;
    endfunction

    function automatic rsp_t predict_allocator(req_t r);
        rsp_t res;
        bit found;
        int pick;
        logic [ADDR_WIDTH:0] pick_len;
        logic [ADDR_WIDTH:0] len;
        logic [ADDR_WIDTH-1:0] nb;
        logic [ADDR_WIDTH-1:0] nxt;
        res.status = ST_OK;
        res.base_address = '0;
        found = 1'b0;
        pick = 0;
        pick_len = '0;
        case (op_t'(r.op))
            OP_ALLOC:
            begin
                if (fit_t'(r.fit_mode) == FIT_BAD)
                    res.status = ST_BAD_MODE;
                else if (shadow_count >= MAX_SEGMENTS)
                    res.status = ST_FULL;
                else if (r.request_size == '0)
                    res.status = ST_NO_HOLE;
                else
                begin
                    for (int i = 0; i <= shadow_count; i++)
                    begin
                        len = hole_length(i);
                        if (len < {1'b0, r.request_size})
                            continue;
                        if (!found)
                        begin
                            found = 1'b1;
                            pick = i;
                            pick_len = len;
                            if (fit_t'(r.fit_mode) == FIT_FIRST)
                                break;
                        end
                        else if ((fit_t'(r.fit_mode) == FIT_BEST && len < pick_len) ||
                                 (fit_t'(r.fit_mode) == FIT_WORST && len > pick_len))
                        begin
                            pick = i;
                            pick_len = len;
                        end
                    end
                    if (!found)
                        res.status = ST_NO_HOLE;
                    else
                    begin
                        len = hole_from(pick);
                        nb = len[ADDR_WIDTH-1:0];
                        for (int i = shadow_count; i > pick; i--)
                        begin
                            shadow_base[i] = shadow_base[i-1];
                            shadow_size[i] = shadow_size[i-1];
                            shadow_owner[i] = shadow_owner[i-1];
                        end
                        shadow_base[pick] = nb;
                        shadow_size[pick] = r.request_size;
                        shadow_owner[pick] = r.owner_id;
                        shadow_count++;
                        res.base_address = nb;
                    end
                end
            end
            OP_RELEASE:
            begin
                res.status = ST_NO_OWNER;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_owner[i] == r.owner_id)
                    begin
                        for (int k = i; k + 1 < shadow_count; k++)
                        begin
                            shadow_base[k] = shadow_base[k+1];
                            shadow_size[k] = shadow_size[k+1];
                            shadow_owner[k] = shadow_owner[k+1];
                        end
                        shadow_count--;
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            OP_COMPACT:
            begin
                nxt = '0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    shadow_base[i] = nxt;
                    nxt = shadow_base[i] + shadow_size[i];
                end
                res.base_address = nxt;
            end
            default:
                res.status = ST_BAD_MODE;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic int idle_roll();
        if (quiet_phase)
            return 0;
        return ($urandom_range(0, 99) < 36) ? 1 : 0;
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_ch.valid)
                expected_rsps.push_back(predict_allocator(req_ch.data));
            if (pending_reqs.size() != 0 && idle_roll() == 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_reqs.pop_front();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response monitor.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.data.status !== want.status)
                        report_mismatch("status", rsp_ch.data.status, want.status);
                    if (rsp_ch.data.base_address !== want.base_address)
                        report_mismatch("base_address", rsp_ch.data.base_address,
                                        want.base_address);
                end
            end
            rsp_ch.ready <= (idle_roll() == 0);
        end
    end

    // Configuration driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.data  <= '0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            shadow_mem_size <= cfg_ch.data;
            cfg_ch.valid <= 1'b0;
        end
        else if (cfg_go && !cfg_ch.valid)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= cfg_pending;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic req_t make_req(op_t op, int owner, int sz, fit_t mode);
        req_t r;
        r.op = op;
        r.owner_id = owner[OWNER_WIDTH-1:0];
        r.request_size = sz[ADDR_WIDTH-1:0];
        r.fit_mode = mode;
        return r;
    endfunction

    function automatic int rand_size(logic [ADDR_WIDTH-1:0] mem);
        int m;
        m = $urandom_range(0, 99);
        if (m < 5)
            return $urandom_range(0, 24'hFFFFFF);
        if (m < 10)
            return 0;
        if (m < 70)
            return $urandom_range(1, (mem / 40) + 1);
        return $urandom_range(1, (mem / 8) + 1);
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_mem_size(logic [ADDR_WIDTH-1:0] v);
        cfg_pending = v;
        cfg_go = 1'b1;
        @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready))
            @(posedge clk);
        cfg_go = 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int n, logic [ADDR_WIDTH-1:0] mem);
        int m;
        req_t r;
        logic [63:0] raw;
        for (int i = 0; i < n; i++)
        begin
            m = $urandom_range(0, 99);
            if (m < 55)
                r = make_req(OP_ALLOC, $urandom_range(0, 15) == 0 ?
                             $urandom_range(0, 255) : $urandom_range(0, 15),
                             rand_size(mem),
                             fit_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2)));
            else if (m < 88)
                r = make_req(OP_RELEASE, $urandom_range(0, 3) == 0 ?
                             $urandom_range(0, 255) : $urandom_range(0, 15), 0, FIT_FIRST);
            else if (m < 96)
                r = make_req(OP_COMPACT, 0, 0, FIT_FIRST);
            else
                r = make_req(OP_UNUSED, $urandom_range(0, 255),
                             $urandom_range(0, 24'hFFFFFF), fit_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0)
            begin
                raw = {$urandom(), $urandom()};
                r = raw[$bits(req_t)-1:0];
            end
            pending_reqs.push_back(r);
        end
    endtask

    initial
    begin
        logic [ADDR_WIDTH-1:0] sizes [5];
        error_count = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        cfg_go = 1'b0;
        cfg_pending = '0;
        shadow_mem_size = MEM_SIZE_RESET;
        shadow_count = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every op and mode, zero size, bad mode, unknown op, exact fit.
        pending_reqs.push_back(make_req(OP_RELEASE, 8'hFF, 0, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_ALLOC, 0, 0, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 100, FIT_BAD));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 24'hFFFFFF, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_ALLOC, 1, 100, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_ALLOC, 2, 50, FIT_BEST));
        pending_reqs.push_back(make_req(OP_ALLOC, 3, 200, FIT_WORST));
        pending_reqs.push_back(make_req(OP_RELEASE, 2, 0, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_ALLOC, 4, 50, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_RELEASE, 1, 0, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_ALLOC, 5, 40, FIT_BEST));
        pending_reqs.push_back(make_req(OP_ALLOC, 6, 10000000 - 350, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_COMPACT, 0, 0, FIT_FIRST));
        pending_reqs.push_back(make_req(OP_UNUSED, 8'hFF, 24'hFFFFFF, FIT_BAD));
        pending_reqs.push_back(make_req(OP_ALLOC, 8'hFF, 1, FIT_WORST));
        wait_drained();

        // A tiny memory below the end of the placed segments, so that shrinking occurs.
        write_mem_size(24'd70);
        for (int i = 0; i < 66; i++)
            pending_reqs.push_back(make_req(OP_ALLOC, i, 1, FIT_FIRST));
        wait_drained();
        write_mem_size(24'd1);
        run_random(40, 24'd1);
        wait_drained();

        sizes[0] = 24'd1000;
        sizes[1] = 24'hFFFFFF;
        sizes[2] = 24'd200;
        sizes[3] = MEM_SIZE_RESET;
        sizes[4] = 24'd5000;
        for (int p = 0; p < 5; p++)
        begin
            write_mem_size(sizes[p]);
            quiet_phase = (p == 2);
            run_random(340, sizes[p]);
            wait_drained();
        end
        quiet_phase = 1'b0;

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
